@@ hdl/cbc_pkg.sv @@
// Shared types, codes and helper functions for the cartridge bank controller.
// Used by cbc_mapper, cbc_ram_ctrl and the top level; depends on nothing else.
package cbc_pkg;

    // External RAM window size in bytes; the RAM array is this deep.
    localparam int RAM_WINDOW_BYTES = 8192;
    localparam int RAM_ADDR_W       = $clog2(RAM_WINDOW_BYTES);
    localparam logic [13:0] RAM_WINDOW_LIM = 14'(RAM_WINDOW_BYTES);
    localparam logic [7:0]  RAM_FILL       = 8'hFF;

    // Bus commands.
    localparam logic [1:0] CMD_CTRL  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Mapper types.
    localparam logic [2:0] MAP_NONE  = 3'd0;
    localparam logic [2:0] MAP_TYPE1 = 3'd1;
    localparam logic [2:0] MAP_TYPE2 = 3'd2;
    localparam logic [2:0] MAP_TYPE3 = 3'd3;
    localparam logic [2:0] MAP_TYPE5 = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAPPER     = 2'd0;
    localparam logic [1:0] REG_BANK_COUNT = 2'd1;
    localparam logic [1:0] REG_RAM_SIZE   = 2'd2;

    // 8 KiB regions of the bus address, taken from address bits 15:13.
    localparam logic [2:0] REGION_ENABLE = 3'd0;
    localparam logic [2:0] REGION_BANK   = 3'd1;
    localparam logic [2:0] REGION_SEL    = 3'd2;
    localparam logic [2:0] REGION_MODE   = 3'd3;
    localparam logic [2:0] REGION_RAM    = 3'd5;

    localparam logic [3:0] ENABLE_CODE   = 4'hA;
    localparam logic [7:0] TYPE2_EN_MASK = 8'h0A;
    localparam logic [7:0] MASK_TYPE1    = 8'h1F;
    localparam logic [7:0] MASK_TYPE2    = 8'h0F;
    localparam logic [7:0] MASK_TYPE3    = 8'h7F;
    localparam logic [7:0] MASK_TYPE5SEL = 8'h0F;
    localparam logic [7:0] MASK_SEL      = 8'h03;

    typedef struct packed {
        logic handled;
        logic changed;
    } map_status_t;

    typedef struct packed {
        logic clearing;
        logic ok;
        logic dirty;
    } ram_status_t;

    // A bank number of zero selects bank one.
    function automatic logic [7:0] nz_bank(input logic [7:0] v);
        nz_bank = (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Effective bank: low register with the select in bits 5-6, clamped
    // to count-1 when the count is below 256.
    function automatic logic [7:0] clamp_bank(input logic [7:0] low,
                                              input logic [7:0] sel,
                                              input logic [8:0] count);
        logic [7:0] bank;
        logic [8:0] last;
        bank = low | ((sel & MASK_SEL) << 5);
        last = count - 9'd1;
        if (!count[8] && ({1'b0, bank} >= count))
        begin
            bank = last[7:0];
        end
        clamp_bank = bank;
    endfunction

endpackage

@@ hdl/cbc_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// Standalone; no package needed.
module cbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cbc_mapper.sv @@
// Control register decode and ROM bank state for the supported mapper types.
// Depends on cbc_pkg.
module cbc_mapper
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [2:0]  mapper_type,
    input  logic [8:0]  rom_bank_count,
    output map_status_t status,
    output logic [7:0]  rom_bank,
    output logic        ram_enable
);

    logic [7:0] low_reg, low_next;
    logic [7:0] sel_reg, sel_next;
    logic       mode_reg, mode_next;
    logic       en_reg, en_next;
    logic [7:0] bank_reg, bank_next;
    logic [2:0] region;

    assign region = address[15:13];

    always_comb
    begin
        low_next = low_reg;
        sel_next = sel_reg;
        mode_next = mode_reg;
        en_next = en_reg;
        status = '0;
        if (wr_en)
        begin
            unique case (mapper_type)
                MAP_NONE:
                begin
                    status.handled = (region == REGION_RAM);
                end
                MAP_TYPE1:
                begin
                    unique case (region)
                        REGION_ENABLE:
                        begin
                            status.handled = 1'b1;
                            en_next = (data[3:0] == ENABLE_CODE);
                        end
                        REGION_BANK:
                        begin
                            status.handled = 1'b1;
                            status.changed = 1'b1;
                            low_next = nz_bank(data & MASK_TYPE1);
                        end
                        REGION_SEL:
                        begin
                            status.handled = 1'b1;
                            if (!mode_reg)
                            begin
                                sel_next = data & MASK_SEL;
                            end
                            else
                            begin
                                status.changed = 1'b1;
                                low_next = (low_reg & MASK_TYPE1) | ((data & MASK_SEL) << 5);
                            end
                        end
                        REGION_MODE:
                        begin
                            status.handled = 1'b1;
                            mode_next = data[0];
                        end
                        default:
                        begin
                            status.handled = 1'b0;
                        end
                    endcase
                end
                MAP_TYPE2:
                begin
                    if (region == REGION_ENABLE)
                    begin
                        status.handled = 1'b1;
                        // Address bit 12 set also writes the bank register; the enable is written in either case.
                        if (address[12])
                        begin
                            status.changed = 1'b1;
                            low_next = nz_bank(data & MASK_TYPE2);
                        end
                        en_next = ((data & TYPE2_EN_MASK) == TYPE2_EN_MASK);
                    end
                end
                MAP_TYPE3, MAP_TYPE5:
                begin
                    unique case (region)
                        REGION_ENABLE:
                        begin
                            status.handled = 1'b1;
                            en_next = (data[3:0] == ENABLE_CODE);
                        end
                        REGION_BANK:
                        begin
                            status.handled = 1'b1;
                            status.changed = 1'b1;
                            low_next = (mapper_type == MAP_TYPE3) ?
                                       nz_bank(data & MASK_TYPE3) : data;
                        end
                        REGION_SEL:
                        begin
                            status.handled = 1'b1;
                            sel_next = (mapper_type == MAP_TYPE3) ? data : (data & MASK_TYPE5SEL);
                        end
                        REGION_MODE:
                        begin
                            status.handled = 1'b1;
                        end
                        default:
                        begin
                            status.handled = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    status = '0;
                end
            endcase
        end
        bank_next = status.changed ? clamp_bank(low_next, sel_reg, rom_bank_count) : bank_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= 8'd1;
            sel_reg  <= 8'd0;
            mode_reg <= 1'b0;
            en_reg   <= 1'b0;
            bank_reg <= 8'd1;
        end
        else
        begin
            low_reg  <= low_next;
            sel_reg  <= sel_next;
            mode_reg <= mode_next;
            en_reg   <= en_next;
            bank_reg <= bank_next;
        end
    end

    assign rom_bank   = bank_reg;
    assign ram_enable = en_reg;

endmodule

@@ hdl/cbc_ram_ctrl.sv @@
// External RAM access: window and size check, clearing pass after reset,
// save-dirty flag and the RAM array itself.
// Depends on cbc_pkg and cbc_ram.
module cbc_ram_ctrl
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req,
    input  logic        wr,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [2:0]  mapper_type,
    input  logic [13:0] ram_size,
    input  logic        ram_enable,
    output ram_status_t status,
    output logic [7:0]  rdata
);

    localparam logic [RAM_ADDR_W-1:0] RAM_LAST = RAM_ADDR_W'(RAM_WINDOW_BYTES - 1);

    logic                  clr_active_reg, clr_active_next;
    logic [RAM_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                  dirty_reg, dirty_next;
    logic [13:0]           offset;
    logic                  in_window;
    logic                  access_ok;
    logic                  mem_we;
    logic [RAM_ADDR_W-1:0] mem_addr;
    logic [7:0]            mem_wdata;

    assign offset    = {1'b0, address[12:0]};
    assign in_window = (address[15:13] == REGION_RAM);
    assign access_ok = (mapper_type != MAP_NONE) && ram_enable && in_window &&
                       (offset < ram_size) && (offset < RAM_WINDOW_LIM);

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next = clr_addr_reg;
        dirty_next = dirty_reg;
        if (clr_active_reg)
        begin
            // Sweep every entry with the erased value, one a cycle.
            mem_we = 1'b1;
            mem_addr = clr_addr_reg;
            mem_wdata = RAM_FILL;
            if (clr_addr_reg == RAM_LAST)
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
        else
        begin
            mem_we = req && wr && access_ok;
            mem_addr = address[RAM_ADDR_W-1:0];
            mem_wdata = data;
            if (mem_we)
            begin
                dirty_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            dirty_reg      <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            dirty_reg      <= dirty_next;
        end
    end

    cbc_ram #(
        .WIDTH(8),
        .DEPTH(RAM_WINDOW_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    assign status.clearing = clr_active_reg;
    assign status.ok       = access_ok;
    assign status.dirty    = dirty_reg;

endmodule

@@ hdl/cartridge_bank_controller_core.sv @@
// Top level of the cartridge bank controller: command channel, result
// strobe and configuration registers. Depends on cbc_pkg, cbc_mapper and
// cbc_ram_ctrl.
//
// Usage: a bus access (command, address, data) is taken at a rising edge
// with start high and busy low. In the next cycle done is high for exactly
// one cycle with the result word; rom_bank, ram_enable_now and save_dirty
// show the state after that access. A new word can be started in every
// cycle while busy is low, so throughput is one word per cycle; the RAM
// read port is used once per word and its read is registered, which places
// the result in the done cycle.
// After reset, busy stays high while the external RAM is swept to 0xFF;
// configuration writes are taken during that time. Reset also returns the
// bank registers to bank one and clears the RAM enable and save-dirty flags.
// The receiver cannot stall: each result word must be taken in the cycle
// that done marks. Configuration must be written over the APB port only while
// no access is in flight; the block itself does not enforce this. Mapper type
// is at 0x0, ROM bank count at 0x4, RAM size at 0x8.
module cartridge_bank_controller_core
    import cbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        done,
    output logic        handled,
    output logic        rom_bank_changed,
    output logic [7:0]  rom_bank,
    output logic        ram_ok,
    output logic [7:0]  read_data,
    output logic        ram_enable_now,
    output logic        save_dirty
);

    logic [2:0]  mapper_type_reg;
    logic [8:0]  rom_bank_count_reg;
    logic [13:0] ram_size_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        accept;
    logic        is_ctrl;
    logic        is_ram;
    map_status_t map_st;
    ram_status_t ram_st;
    logic [7:0]  ram_rdata;
    logic        ram_en;

    logic        done_reg;
    logic        handled_reg;
    logic        changed_reg;
    logic        ok_reg;
    logic        rd_sel_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mapper_type_reg    <= MAP_NONE;
            rom_bank_count_reg <= 9'd2;
            ram_size_reg       <= 14'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_MAPPER:     mapper_type_reg    <= pwdata[2:0];
                REG_BANK_COUNT: rom_bank_count_reg <= pwdata[8:0];
                REG_RAM_SIZE:   ram_size_reg       <= pwdata[13:0];
                default:        mapper_type_reg    <= mapper_type_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_MAPPER:     prdata = {29'd0, mapper_type_reg};
            REG_BANK_COUNT: prdata = {23'd0, rom_bank_count_reg};
            REG_RAM_SIZE:   prdata = {18'd0, ram_size_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign busy    = ram_st.clearing;
    assign accept  = start && !busy;
    assign is_ctrl = (command == CMD_CTRL);
    assign is_ram  = (command == CMD_READ) || (command == CMD_WRITE);

    cbc_mapper u_mapper (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (accept && is_ctrl),
        .address        (address),
        .data           (data),
        .mapper_type    (mapper_type_reg),
        .rom_bank_count (rom_bank_count_reg),
        .status         (map_st),
        .rom_bank       (rom_bank),
        .ram_enable     (ram_en)
    );

    cbc_ram_ctrl u_ram_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (accept && is_ram),
        .wr          (command == CMD_WRITE),
        .address     (address),
        .data        (data),
        .mapper_type (mapper_type_reg),
        .ram_size    (ram_size_reg),
        .ram_enable  (ram_en),
        .status      (ram_st),
        .rdata       (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= 1'b0;
            handled_reg <= 1'b0;
            changed_reg <= 1'b0;
            ok_reg      <= 1'b0;
            rd_sel_reg  <= 1'b0;
        end
        else
        begin
            done_reg    <= accept;
            handled_reg <= map_st.handled;
            changed_reg <= map_st.changed;
            ok_reg      <= accept && is_ram && ram_st.ok;
            rd_sel_reg  <= accept && (command == CMD_READ) && ram_st.ok;
        end
    end

    assign done             = done_reg;
    assign handled          = handled_reg;
    assign rom_bank_changed = changed_reg;
    assign ram_ok           = ok_reg;
    // The RAM word read at the accepting edge is on ram_rdata in the done cycle.
    assign read_data        = rd_sel_reg ? ram_rdata : 8'd0;
    assign ram_enable_now   = ram_en;
    assign save_dirty       = ram_st.dirty;

endmodule

@@ hdl/cbc_checker.sv @@
// Port-level checks for the cartridge bank controller, bound to the top level.
// Depends on cartridge_bank_controller_core.
module cbc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       handled,
    input logic       rom_bank_changed,
    input logic       ram_ok,
    input logic [7:0] read_data,
    input logic       save_dirty
);

    // Every result word answers a word accepted in the cycle before.
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted word");

    a_bank_change_handled: assert property (@(posedge clk) disable iff (!rst_n)
        done && rom_bank_changed |-> handled)
        else $error("bank recomputed by an undecoded write");

    a_no_mixed_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && handled |-> !ram_ok)
        else $error("control write reported as a RAM access");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ram_ok |-> read_data == 8'd0)
        else $error("read data on a refused access");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(save_dirty))
        else $error("save dirty flag cleared without reset");

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .handled          (handled),
    .rom_bank_changed (rom_bank_changed),
    .ram_ok           (ram_ok),
    .read_data        (read_data),
    .save_dirty       (save_dirty)
);
